[rtl/wpd_pkg.sv]
// ----------------------------------------------------------------------------
// wpd_pkg
// Shared types and constants of the word packet deframer.
// ----------------------------------------------------------------------------
package wpd_pkg;

  localparam int BufWords = 64;
  localparam int IdxW     = (BufWords > 1) ? $clog2(BufWords) : 1;
  localparam int CntW     = $clog2(BufWords + 1);

  localparam logic [31:0] HeadSignRst  = 32'd1;
  localparam logic [31:0] StartSignRst = 32'd2;
  localparam logic [31:0] EndSignRst   = 32'd3;

  typedef enum logic [1:0] {
    REG_HEAD_SIGN  = 2'd0,
    REG_START_SIGN = 2'd1,
    REG_END_SIGN   = 2'd2
  } reg_idx_e;

  typedef enum logic [2:0] {
    KIND_ACCEPT    = 3'd0,
    KIND_WORD      = 3'd1,
    KIND_BADSUM    = 3'd2,
    KIND_HEADERR   = 3'd3,
    KIND_STARTERR  = 3'd4,
    KIND_OVERFLOW  = 3'd5
  } kind_e;

  typedef struct packed {
    logic  latch_size;
    logic  clear;
    logic  store;
    logic  emit;
    kind_e kind;
    logic  size_sel;
    logic  deliver_start;
    logic  deliver_step;
  } cmd_t;

  typedef struct packed {
    logic head_match;
    logic start_match;
    logic end_match;
    logic sum_ok;
    logic ovf;
    logic rd_last;
  } status_t;

endpackage

[rtl/wpd_ctrl.sv]
// ----------------------------------------------------------------------------
// wpd_ctrl
// Framing state machine: walks head, size, start, data and checksum, then
// steps the buffer readout of a good packet.
// ----------------------------------------------------------------------------
module wpd_ctrl import wpd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  status_t status_i,
  output cmd_t    cmd_o,
  output logic    busy_o
);

  typedef enum logic [6:0] {
    ST_HEAD    = 7'b0000001,
    ST_SIZE    = 7'b0000010,
    ST_START   = 7'b0000100,
    ST_FIRST   = 7'b0001000,
    ST_DATA    = 7'b0010000,
    ST_CHECK   = 7'b0100000,
    ST_DELIVER = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign busy_o = (state_q == ST_DELIVER);
  assign accept = start_i && !busy_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.kind = KIND_ACCEPT;
    case (state_q)
      ST_HEAD: begin
        if (accept) begin
          cmd_o.emit = 1'b1;
          if (status_i.head_match) begin
            state_d = ST_SIZE;
          end else begin
            cmd_o.kind = KIND_HEADERR;
          end
        end
      end
      ST_SIZE: begin
        if (accept) begin
          cmd_o.emit       = 1'b1;
          cmd_o.latch_size = 1'b1;
          state_d          = ST_START;
        end
      end
      ST_START: begin
        if (accept) begin
          cmd_o.emit = 1'b1;
          if (status_i.start_match) begin
            state_d = ST_FIRST;
          end else begin
            cmd_o.kind = KIND_STARTERR;
          end
        end
      end
      ST_FIRST: begin
        if (accept) begin
          cmd_o.emit = 1'b1;
          // an end sign right after the start sign is dropped
          if (!status_i.end_match) begin
            cmd_o.clear = 1'b1;
            cmd_o.store = 1'b1;
            state_d     = ST_DATA;
          end
        end
      end
      ST_DATA: begin
        if (accept) begin
          cmd_o.emit = 1'b1;
          if (status_i.end_match) begin
            state_d = ST_CHECK;
          end else begin
            cmd_o.store = 1'b1;
          end
        end
      end
      ST_CHECK: begin
        if (accept) begin
          state_d = ST_HEAD;
          if (status_i.ovf) begin
            cmd_o.emit     = 1'b1;
            cmd_o.kind     = KIND_OVERFLOW;
            cmd_o.size_sel = 1'b1;
          end else if (!status_i.sum_ok) begin
            cmd_o.emit     = 1'b1;
            cmd_o.kind     = KIND_BADSUM;
            cmd_o.size_sel = 1'b1;
          end else begin
            cmd_o.deliver_start = 1'b1;
            state_d             = ST_DELIVER;
          end
        end
      end
      ST_DELIVER: begin
        cmd_o.deliver_step = 1'b1;
        if (status_i.rd_last) begin
          state_d = ST_HEAD;
        end
      end
      default: begin
        state_d = ST_HEAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_HEAD;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[rtl/wpd_datapath.sv]
// ----------------------------------------------------------------------------
// wpd_datapath
// Packet buffer, running sum, word count, overflow flag and result registers.
// ----------------------------------------------------------------------------
module wpd_datapath import wpd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [31:0] data_word_i,
  input  logic [31:0] head_sign_i,
  input  logic [31:0] start_sign_i,
  input  logic [31:0] end_sign_i,
  input  cmd_t        cmd_i,
  output status_t     status_o,
  output logic        result_valid_o,
  output logic [2:0]  kind_o,
  output logic [31:0] payload_word_o,
  output logic [31:0] byte_size_o,
  output logic        last_o
);

  logic [31:0]     mem [BufWords];
  logic [31:0]     size_q;
  logic [31:0]     sum_q;
  logic [CntW-1:0] count_q;
  logic            ovf_q;
  logic [IdxW-1:0] rd_idx_q;
  logic [31:0]     rd_data_q;

  logic            strobe_q;
  kind_e           kind_q;
  logic            last_q;
  logic            word_sel_q;
  logic [31:0]     out_size_q;

  logic [31:0]     sum_base;
  logic [CntW-1:0] cnt_base;
  logic            ovf_base;
  logic            room;
  logic [CntW-1:0] rd_next;

  // first data word restarts the packet before it is stored
  assign sum_base = cmd_i.clear ? '0 : sum_q;
  assign cnt_base = cmd_i.clear ? '0 : count_q;
  assign ovf_base = cmd_i.clear ? 1'b0 : ovf_q;
  assign room     = (cnt_base < CntW'(BufWords));
  assign rd_next  = CntW'(rd_idx_q) + CntW'(1);

  assign status_o.head_match  = (data_word_i == head_sign_i);
  assign status_o.start_match = (data_word_i == start_sign_i);
  assign status_o.end_match   = (data_word_i == end_sign_i);
  assign status_o.sum_ok      = (data_word_i == sum_q) && (count_q != '0);
  assign status_o.ovf         = ovf_q;
  assign status_o.rd_last     = (rd_next == count_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.store && room) begin
      mem[cnt_base[IdxW-1:0]] <= data_word_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.deliver_step) begin
      rd_data_q <= mem[rd_idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q   <= '0;
      sum_q    <= '0;
      count_q  <= '0;
      ovf_q    <= 1'b0;
      rd_idx_q <= '0;
    end else begin
      if (cmd_i.latch_size) begin
        size_q <= data_word_i;
      end
      if (cmd_i.store) begin
        sum_q <= sum_base + data_word_i;
        if (room) begin
          count_q <= cnt_base + CntW'(1);
          ovf_q   <= ovf_base;
        end else begin
          count_q <= cnt_base;
          ovf_q   <= 1'b1;
        end
      end
      if (cmd_i.deliver_start) begin
        rd_idx_q <= '0;
      end else if (cmd_i.deliver_step) begin
        rd_idx_q <= rd_idx_q + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q   <= 1'b0;
      kind_q     <= KIND_ACCEPT;
      last_q     <= 1'b0;
      word_sel_q <= 1'b0;
    end else begin
      strobe_q <= cmd_i.emit || cmd_i.deliver_step;
      if (cmd_i.deliver_step) begin
        kind_q     <= KIND_WORD;
        last_q     <= status_o.rd_last;
        word_sel_q <= 1'b1;
      end else if (cmd_i.emit) begin
        kind_q     <= cmd_i.kind;
        last_q     <= 1'b1;
        word_sel_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.deliver_step) begin
      out_size_q <= size_q;
    end else if (cmd_i.emit) begin
      out_size_q <= cmd_i.size_sel ? size_q : '0;
    end
  end

  assign result_valid_o = strobe_q;
  assign kind_o         = kind_q;
  assign last_o         = last_q;
  assign byte_size_o    = out_size_q;
  assign payload_word_o = word_sel_q ? rd_data_q : '0;

endmodule

[rtl/word_packet_deframer_unit.sv]
// ----------------------------------------------------------------------------
// word_packet_deframer_unit
// Deframes head/size/start/data/end/checksum packets from a 32-bit word stream.
// ----------------------------------------------------------------------------
// One word is taken per cycle while busy_o is low; each taken word other than
// a validating checksum gives its result on the result ports in the next cycle,
// marked by result_valid_o for a single cycle. The receiver cannot stall:
// every strobed beat must be taken.
// A checksum word that validates a packet of N stored words starts the
// readout of the packet buffer through its single read port, one word per
// cycle, so busy_o stays high until the last of the N words (1 to 64) is read
// and the N word beats follow back to back, the first in the cycle after busy_o
// rises and the final one with last_o set. No words are taken during that
// readout. Configuration writes are expected only while idle.
module word_packet_deframer_unit import wpd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [31:0] data_word_i,
  output logic        result_valid_o,
  output logic [2:0]  kind_o,
  output logic [31:0] payload_word_o,
  output logic [31:0] byte_size_o,
  output logic        last_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [31:0] head_sign_q;
  logic [31:0] start_sign_q;
  logic [31:0] end_sign_q;
  logic        cfg_wr;
  reg_idx_e    reg_idx;
  cmd_t        cmd;
  status_t     status;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_sign_q  <= HeadSignRst;
      start_sign_q <= StartSignRst;
      end_sign_q   <= EndSignRst;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_HEAD_SIGN:  head_sign_q  <= pwdata;
        REG_START_SIGN: start_sign_q <= pwdata;
        REG_END_SIGN:   end_sign_q   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_HEAD_SIGN:  prdata = head_sign_q;
      REG_START_SIGN: prdata = start_sign_q;
      REG_END_SIGN:   prdata = end_sign_q;
      default:        prdata = '0;
    endcase
  end

  wpd_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  wpd_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .data_word_i    (data_word_i),
    .head_sign_i    (head_sign_q),
    .start_sign_i   (start_sign_q),
    .end_sign_i     (end_sign_q),
    .cmd_i          (cmd),
    .status_o       (status),
    .result_valid_o (result_valid_o),
    .kind_o         (kind_o),
    .payload_word_o (payload_word_o),
    .byte_size_o    (byte_size_o),
    .last_o         (last_o)
  );

`ifndef SYNTHESIS
  // every readout cycle puts a word beat out in the next cycle
  a_deliver_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |=> (result_valid_o && (kind_o == KIND_WORD)))
    else $error("readout cycle without a word beat");

  // status beats always have last_o set
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (kind_o != KIND_WORD)) |-> last_o)
    else $error("status beat without last");

  // the readout ends with the last word on the ports
  a_deliver_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> (result_valid_o && last_o && (kind_o == KIND_WORD)))
    else $error("readout ended without last word");
`endif

endmodule
